### src/fcpa_pkg.sv
// Shared types, constants and codes of the fixed chunk pool allocator.
package fcpa_pkg;

    // Fixed field widths
    localparam int ADDR_BITS   = 48;
    localparam int SIZE_BITS   = 32;
    localparam int COUNT_BITS  = 11;
    localparam int STATUS_BITS = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 48;

    // Defaults
    localparam int MAX_CHUNKS_DEF  = 1024;
    localparam int ALIGNMENT       = 8;
    localparam int CHUNK_SIZE_RST  = 64;
    localparam int CHUNK_COUNT_RST = 1024;

    // Request kinds
    localparam logic REQ_GET  = 1'b0;
    localparam logic REQ_FREE = 1'b1;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY       = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BELOW       = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_ABOVE       = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_MISALIGNED  = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_DOUBLE_FREE = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHUNK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHUNK_COUNT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_ADDRESS = 2'd2;

    // Request word
    typedef struct packed {
        logic                 req_type;
        logic [ADDR_BITS-1:0] chunk_address;
    } req_t;

    // Result word
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ADDR_BITS-1:0]   granted_address;
        logic [COUNT_BITS-1:0]  used_count;
        logic [COUNT_BITS-1:0]  min_free;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic                   capture;
        logic                   stack_read;
        logic                   get_pop;
        logic                   get_mul;
        logic                   get_grant;
        logic                   free_sub;
        logic                   div_init;
        logic                   div_step;
        logic                   map_read;
        logic                   free_push;
        logic                   load_out;
        logic [STATUS_BITS-1:0] status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic stack_empty;
        logic below;
        logic above;
        logic div_last;
        logic misaligned;
        logic double_free;
        logic out_free;
    } stat_t;

endpackage

### src/fcpa_stream_if.sv
// Valid/ready channel carrying one word of a given type.
interface fcpa_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/fcpa_ctrl.sv
// Controller state machine sequencing get and free requests.
module fcpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_free,
    output logic           in_ready,
    input  fcpa_pkg::stat_t stat,
    output fcpa_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_GET_READ   = 4'd1;
    localparam logic [3:0] S_GET_POP    = 4'd2;
    localparam logic [3:0] S_GET_MUL    = 4'd3;
    localparam logic [3:0] S_GET_GRANT  = 4'd4;
    localparam logic [3:0] S_FREE_SUB   = 4'd5;
    localparam logic [3:0] S_FREE_RANGE = 4'd6;
    localparam logic [3:0] S_FREE_DIV   = 4'd7;
    localparam logic [3:0] S_FREE_ALIGN = 4'd8;
    localparam logic [3:0] S_FREE_CHECK = 4'd9;
    localparam logic [3:0] S_DONE       = 4'd10;

    logic [3:0]                       state_reg;
    logic [3:0]                       state_next;
    logic [fcpa_pkg::STATUS_BITS-1:0] status_reg;
    logic [fcpa_pkg::STATUS_BITS-1:0] status_next;

    // Advance state and hold the result code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= fcpa_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // Decode state into commands
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    status_next = fcpa_pkg::ST_OK;
                    state_next  = (in_free == fcpa_pkg::REQ_FREE) ? S_FREE_SUB : S_GET_READ;
                end
            end
            S_GET_READ:
            begin
                if (stat.stack_empty)
                begin
                    status_next = fcpa_pkg::ST_EMPTY;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.stack_read = 1'b1;
                    state_next     = S_GET_POP;
                end
            end
            S_GET_POP:
            begin
                cmd.get_pop = 1'b1;
                state_next  = S_GET_MUL;
            end
            S_GET_MUL:
            begin
                cmd.get_mul = 1'b1;
                state_next  = S_GET_GRANT;
            end
            S_GET_GRANT:
            begin
                cmd.get_grant = 1'b1;
                state_next    = S_DONE;
            end
            S_FREE_SUB:
            begin
                if (stat.below)
                begin
                    status_next = fcpa_pkg::ST_BELOW;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.free_sub = 1'b1;
                    state_next   = S_FREE_RANGE;
                end
            end
            S_FREE_RANGE:
            begin
                if (stat.above)
                begin
                    status_next = fcpa_pkg::ST_ABOVE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_FREE_DIV;
                end
            end
            S_FREE_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FREE_ALIGN;
                end
            end
            S_FREE_ALIGN:
            begin
                if (stat.misaligned)
                begin
                    status_next = fcpa_pkg::ST_MISALIGNED;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.map_read = 1'b1;
                    state_next   = S_FREE_CHECK;
                end
            end
            S_FREE_CHECK:
            begin
                if (stat.double_free)
                begin
                    status_next = fcpa_pkg::ST_DOUBLE_FREE;
                end
                else
                begin
                    cmd.free_push = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/fcpa_dp.sv
// Datapath: configuration, free stack, allocation map, multiplier, divider, result register.
module fcpa_dp #(
    parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [fcpa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [fcpa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  fcpa_pkg::req_t                       req_data,
    input  fcpa_pkg::cmd_t                       cmd,
    output fcpa_pkg::stat_t                      stat,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output fcpa_pkg::rsp_t                       rsp_data
);

    localparam int AW   = fcpa_pkg::ADDR_BITS;
    localparam int ZW   = fcpa_pkg::SIZE_BITS;
    localparam int OCW  = fcpa_pkg::COUNT_BITS;
    localparam int IW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW   = $clog2(MAX_CHUNKS + 1);
    localparam int PW   = ZW + CW;
    localparam int SW   = (PW > AW) ? PW : AW;
    localparam int NW   = (CW > 1) ? $clog2(CW) : 1;
    localparam int RST_COUNT = (fcpa_pkg::CHUNK_COUNT_RST > MAX_CHUNKS) ?
                               MAX_CHUNKS : fcpa_pkg::CHUNK_COUNT_RST;
    localparam logic [ZW-1:0] ALIGN_MASK = ZW'(fcpa_pkg::ALIGNMENT - 1);

    // Configuration and pool state
    logic [ZW-1:0]  size_reg;
    logic [AW-1:0]  base_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  depth_reg;
    logic [CW-1:0]  used_reg;
    logic [CW-1:0]  low_reg;

    // Per-request working registers
    logic [AW-1:0]  addr_reg;
    logic [AW-1:0]  off_reg;
    logic [PW-1:0]  prod_reg;
    logic [PW-1:0]  rem_reg;
    logic [PW-1:0]  dvs_reg;
    logic [NW-1:0]  cnt_reg;
    logic [CW-1:0]  q_reg;
    logic [AW-1:0]  grant_reg;
    logic           seen_reg;

    // Memories
    logic [IW-1:0]  stack_mem [MAX_CHUNKS];
    logic           alloc_mem [MAX_CHUNKS];
    logic [IW-1:0]  stack_rd_reg;
    logic           alloc_rd_reg;

    // Result register
    logic           out_valid_reg;
    fcpa_pkg::rsp_t out_reg;

    logic [ZW-1:0]  size_masked;
    logic [ZW-1:0]  size_eff;
    logic [OCW-1:0] count_raw;
    logic [CW-1:0]  count_eff;
    logic [CW-1:0]  depth_dec;
    logic [CW-1:0]  pop_idx;
    logic [CW-1:0]  mul_a;
    logic [SW-1:0]  grant_sum;
    logic [PW-1:0]  rem_sub;
    logic           rem_ge;
    logic           alloc_we;
    logic [IW-1:0]  alloc_wa;

    // Round the written chunk size down to the grid, zero becomes one grid step
    assign size_masked = cfg_data[ZW-1:0] & ~ALIGN_MASK;
    assign size_eff    = (size_masked == '0) ? ZW'(fcpa_pkg::ALIGNMENT) : size_masked;

    // Clamp the written chunk count into one to MAX_CHUNKS
    assign count_raw = cfg_data[OCW-1:0];
    always_comb
    begin
        if (count_raw == '0)
        begin
            count_eff = CW'(1);
        end
        else if (32'(count_raw) > 32'(MAX_CHUNKS))
        begin
            count_eff = CW'(MAX_CHUNKS);
        end
        else
        begin
            count_eff = CW'(count_raw);
        end
    end

    // Entries below the low mark still hold their initial index
    assign depth_dec = depth_reg - CW'(1);
    assign pop_idx   = (depth_reg == low_reg) ? (count_reg - depth_reg)
                                              : CW'(stack_rd_reg);

    assign mul_a     = cmd.free_sub ? (count_reg - CW'(1)) : q_reg;
    assign grant_sum = SW'(base_reg) + SW'(prod_reg);
    assign rem_ge    = (rem_reg >= dvs_reg);
    assign rem_sub   = rem_reg - dvs_reg;

    // Status toward the controller
    assign stat.stack_empty = (depth_reg == '0);
    assign stat.below       = (addr_reg < base_reg);
    assign stat.above       = (SW'(off_reg) > SW'(prod_reg));
    assign stat.div_last    = (cnt_reg == '0);
    assign stat.misaligned  = (rem_reg != '0);
    assign stat.double_free = !(seen_reg && alloc_rd_reg) || (depth_reg >= count_reg);
    assign stat.out_free    = !out_valid_reg || rsp_ready;

    // Configuration and pool bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= ZW'(fcpa_pkg::CHUNK_SIZE_RST);
            base_reg  <= '0;
            count_reg <= CW'(RST_COUNT);
            depth_reg <= CW'(RST_COUNT);
            used_reg  <= '0;
            low_reg   <= CW'(RST_COUNT);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fcpa_pkg::CFG_CHUNK_SIZE:
                begin
                    size_reg <= size_eff;
                end
                fcpa_pkg::CFG_CHUNK_COUNT:
                begin
                    count_reg <= count_eff;
                    depth_reg <= count_eff;
                    used_reg  <= '0;
                    low_reg   <= count_eff;
                end
                fcpa_pkg::CFG_BASE_ADDRESS:
                begin
                    base_reg <= cfg_data[AW-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.get_pop)
        begin
            depth_reg <= depth_dec;
            used_reg  <= used_reg + CW'(1);
            if (depth_dec < low_reg)
            begin
                low_reg <= depth_dec;
            end
        end
        else if (cmd.free_push)
        begin
            depth_reg <= depth_reg + CW'(1);
            if (used_reg != '0)
            begin
                used_reg <= used_reg - CW'(1);
            end
        end
    end

    // Request working registers, multiplier and quotient loop
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg  <= req_data.chunk_address;
            grant_reg <= '0;
        end
        if (cmd.get_pop)
        begin
            q_reg <= pop_idx;
        end
        if (cmd.get_mul || cmd.free_sub)
        begin
            prod_reg <= PW'(size_reg) * PW'(mul_a);
        end
        if (cmd.get_grant)
        begin
            grant_reg <= grant_sum[AW-1:0];
        end
        if (cmd.free_sub)
        begin
            off_reg <= addr_reg - base_reg;
        end
        if (cmd.div_init)
        begin
            rem_reg <= PW'(off_reg);
            dvs_reg <= PW'(size_reg) << (CW - 1);
            cnt_reg <= NW'(CW - 1);
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_sub;
            end
            q_reg   <= (q_reg << 1) | CW'(rem_ge);
            dvs_reg <= dvs_reg >> 1;
            cnt_reg <= cnt_reg - NW'(1);
        end
        if (cmd.map_read)
        begin
            seen_reg <= (q_reg < (count_reg - low_reg));
        end
    end

    // Free stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.free_push)
        begin
            stack_mem[depth_reg[IW-1:0]] <= q_reg[IW-1:0];
        end
        if (cmd.stack_read)
        begin
            stack_rd_reg <= stack_mem[depth_dec[IW-1:0]];
        end
    end

    // Allocation map memory: set on grant, clear on accepted free
    assign alloc_we = cmd.get_mul || cmd.free_push;
    assign alloc_wa = q_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            alloc_mem[alloc_wa] <= cmd.get_mul;
        end
        if (cmd.map_read)
        begin
            alloc_rd_reg <= alloc_mem[q_reg[IW-1:0]];
        end
    end

    // Result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.status          <= cmd.status;
            out_reg.granted_address <= grant_reg;
            out_reg.used_count      <= OCW'(used_reg);
            out_reg.min_free        <= OCW'(low_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

### src/fixed_chunk_pool_allocator_top.sv
// Fixed chunk pool allocator: one request at a time, sequenced controller over a datapath.
// Get: read, pop, multiply and grant states; an empty pool skips to the result. Free:
// subtract, range, divide, align and check states, the divider giving one quotient bit per
// cycle; rejections return earlier. Next request taken in the cycle after the result
// loads; a stalled result word holds the controller. Reset loads chunk size 64, base 0,
// count 1024 and a full free stack at once; a chunk_count write does so too.
module fixed_chunk_pool_allocator_top #(
    parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fcpa_stream_if.sink                         req,
    fcpa_stream_if.source                       rsp,
    input  logic                                cfg_write,
    input  logic [fcpa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fcpa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    fcpa_pkg::cmd_t  cmd;
    fcpa_pkg::stat_t stat;
    fcpa_pkg::req_t  req_word;
    fcpa_pkg::rsp_t  rsp_word;
    logic            req_ready;
    logic            rsp_valid;

    assign req_word  = req.data;
    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_word;

    // Sequence the request
    fcpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_free  (req_word.req_type),
        .in_ready (req_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold pool state and compute
    fcpa_dp #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_word)
    );

`ifndef SYNTHESIS
    // One request in flight: no new word right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    // Result loads only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result overwrote a pending word");

    // Granted address is zero unless the request succeeded
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.data.status != fcpa_pkg::ST_OK)) |-> (rsp.data.granted_address == '0))
        else $error("granted address on a rejected request");

    // A loaded result is presented as valid on the cycle after the load
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> rsp.valid)
        else $error("loaded result not presented");
`endif

endmodule

### tb/fixed_chunk_pool_allocator_top_tb.sv
// Self-checking testbench of the fixed chunk pool allocator: predicted pool state against each result word.
module fixed_chunk_pool_allocator_top_tb;
    import fcpa_pkg::*;

    // Pool state mirror: predicts each result word and holds the words still awaited
    class pool_ledger;
        logic [SIZE_BITS-1:0]  size_reg;
        logic [COUNT_BITS-1:0] count_reg;
        logic [ADDR_BITS-1:0]  base_reg;
        logic [9:0]            free_list [MAX_CHUNKS_DEF];
        bit                    held [MAX_CHUNKS_DEF];
        int unsigned           depth;
        int unsigned           in_use;
        int unsigned           low_mark;
        rsp_t                  awaited [$];
        int unsigned           mismatches;

        function new();
            size_reg   = SIZE_BITS'(CHUNK_SIZE_RST);
            count_reg  = COUNT_BITS'(CHUNK_COUNT_RST);
            base_reg   = '0;
            mismatches = 0;
            init_pool();
        endfunction

        // Size rounded down to the grid; zero falls back to one alignment step
        function longint unsigned grain();
            longint unsigned s;
            s = {size_reg[SIZE_BITS-1:3], 3'b000};
            return (s == 0) ? ALIGNMENT : s;
        endfunction

        // Count clamped to 1..MAX_CHUNKS
        function int unsigned slots();
            if (count_reg == 0) return 1;
            if (count_reg > MAX_CHUNKS_DEF) return MAX_CHUNKS_DEF;
            return count_reg;
        endfunction

        function logic [ADDR_BITS-1:0] grid_address(input int unsigned idx);
            return ADDR_BITS'(base_reg + idx * grain());
        endfunction

        // Refill the stack so that index 0 pops first
        function void init_pool();
            int unsigned n;
            n = slots();
            for (int i = 0; i < MAX_CHUNKS_DEF; i++)
            begin
                free_list[i] = '0;
                held[i]      = 1'b0;
            end
            for (int unsigned i = 0; i < n; i++)
                free_list[i] = 10'(n - 1 - i);
            depth    = n;
            in_use   = 0;
            low_mark = n;
        endfunction

        function void apply_register(input logic [CFG_IDX_BITS-1:0] index,
                                     input logic [CFG_DATA_BITS-1:0] value);
            case (index)
                CFG_CHUNK_SIZE:   size_reg = value[SIZE_BITS-1:0];
                CFG_CHUNK_COUNT:
                begin
                    count_reg = value[COUNT_BITS-1:0];
                    init_pool();
                end
                CFG_BASE_ADDRESS: base_reg = value[ADDR_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Pick a random chunk that is currently handed out
        function bit pick_held(output logic [ADDR_BITS-1:0] addr);
            int unsigned n;
            int unsigned start;
            n = slots();
            start = $urandom_range(n - 1);
            for (int unsigned k = 0; k < n; k++)
            begin
                int unsigned i;
                i = (start + k) % n;
                if (held[i])
                begin
                    addr = grid_address(i);
                    return 1'b1;
                end
            end
            addr = '0;
            return 1'b0;
        endfunction

        // Advance the pool by one accepted request word and queue its result
        function void note_request(input req_t w);
            rsp_t            r;
            int unsigned     n;
            int unsigned     idx;
            longint unsigned g;
            longint unsigned last;
            longint unsigned off;
            logic [ADDR_BITS-1:0] a;
            g = grain();
            n = slots();
            r = '0;
            r.status = ST_OK;
            if (w.req_type == REQ_GET)
            begin
                if (depth == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    depth--;
                    idx = free_list[depth];
                    held[idx] = 1'b1;
                    in_use++;
                    if (n - in_use < low_mark)
                        low_mark = n - in_use;
                    r.granted_address = ADDR_BITS'(base_reg + idx * g);
                end
            end
            else
            begin
                a = w.chunk_address;
                last = g * (n - 1);
                if (a < base_reg)
                    r.status = ST_BELOW;
                else
                begin
                    off = a - base_reg;
                    if (off > last)
                        r.status = ST_ABOVE;
                    else if (off % g != 0)
                        r.status = ST_MISALIGNED;
                    else
                    begin
                        idx = 32'(off / g);
                        if (!held[idx] || depth >= n)
                            r.status = ST_DOUBLE_FREE;
                        else
                        begin
                            held[idx] = 1'b0;
                            free_list[depth] = 10'(idx);
                            depth++;
                            if (in_use > 0)
                                in_use--;
                        end
                    end
                end
            end
            r.used_count = 11'(in_use);
            r.min_free   = 11'(low_mark);
            awaited.push_back(r);
        endfunction

        function void match_field(input string label, input logic [63:0] want,
                                  input logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t %s mismatch: expected %0h actual %0h", $time, label, want, got);
                mismatches++;
            end
        endfunction

        // Compare a result word with the oldest awaited one
        function void check_result(input rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            match_field("status", want.status, got.status);
            match_field("granted_address", want.granted_address, got.granted_address);
            match_field("used_count", want.used_count, got.used_count);
            match_field("min_free", want.min_free, got.min_free);
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    bit                       calm = 1'b0;
    int unsigned              hold_cycles = 0;
    pool_ledger               ledger;

    fcpa_stream_if #(.word_t(req_t)) req_ch ();
    fcpa_stream_if #(.word_t(rsp_t)) rsp_ch ();

    fixed_chunk_pool_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5000000;
        $display("fixed_chunk_pool_allocator_top_tb: errors");
        $finish;
    end

    // Check each result word; stall ready in random bursts unless calm
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                ledger.check_result(rsp_ch.data);
            if (hold_cycles != 0)
            begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                hold_cycles = $urandom_range(0, 11);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    function automatic logic [ADDR_BITS-1:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_BITS-1:0];
    endfunction

    function automatic req_t get_word();
        return '{req_type: REQ_GET, chunk_address: rand48()};
    endfunction

    function automatic req_t free_word(input logic [ADDR_BITS-1:0] addr);
        return '{req_type: REQ_FREE, chunk_address: addr};
    endfunction

    // Mostly gets and frees of live chunks; the rest misaligned, out of range or random
    function automatic req_t next_request();
        req_t                 w;
        logic [ADDR_BITS-1:0] a;
        logic [63:0]          span;
        int unsigned          roll;
        roll = $urandom_range(0, 99);
        w = free_word(rand48());
        if (roll < 45)
            w = get_word();
        else if (roll < 80)
        begin
            if (!ledger.pick_held(a))
                a = ledger.grid_address($urandom_range(ledger.slots() - 1));
            w.chunk_address = a;
        end
        else if (roll < 86)
        begin
            if (!ledger.pick_held(a))
                a = ledger.grid_address(0);
            w.chunk_address = a + $urandom_range(1, ALIGNMENT - 1);
        end
        else if (roll < 91)
            w.chunk_address = ledger.base_reg - $urandom_range(1, 4096);
        else if (roll < 96)
        begin
            span = ledger.grain() * ledger.slots();
            w.chunk_address = ADDR_BITS'(ledger.base_reg + span + $urandom_range(0, 4095));
        end
        return w;
    endfunction

    // Offer one request word after an optional idle burst; return at its accept edge
    task automatic send_word(input req_t w);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        ledger.note_request(w);
    endtask

    // Drop valid and hold until every awaited result word is in
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.awaited.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        ledger.apply_register(index, value);
    endtask

    task automatic program_pool(input logic [CFG_DATA_BITS-1:0] size_word,
                                input logic [CFG_DATA_BITS-1:0] count_word,
                                input logic [CFG_DATA_BITS-1:0] base_word);
        write_register(CFG_CHUNK_SIZE, size_word);
        write_register(CFG_CHUNK_COUNT, count_word);
        write_register(CFG_BASE_ADDRESS, base_word);
        cfg_write <= 1'b0;
    endtask

    // Reprogram the pool, then run random traffic against it
    task automatic random_phase(input int unsigned phase, input int unsigned items);
        logic [SIZE_BITS-1:0]  size_val;
        logic [COUNT_BITS-1:0] count_val;
        logic [ADDR_BITS-1:0]  base_val;
        logic [63:0]           junk;
        junk = {$urandom(), $urandom()};
        case ((phase + 2) % 5)
            0:       size_val = 32'd8;
            1:       size_val = $urandom();
            2:       size_val = 32'hFFFF_FFFF;
            3:       size_val = $urandom_range(0, 7);
            default: size_val = $urandom_range(1, 256) * 8 + $urandom_range(0, 7);
        endcase
        case (phase % 6)
            0:       count_val = 11'd1;
            1:       count_val = 11'd1024;
            2:       count_val = COUNT_BITS'($urandom_range(1025, 2047));
            3:       count_val = 11'd0;
            default: count_val = COUNT_BITS'($urandom_range(2, 24));
        endcase
        case ((phase + 1) % 4)
            0:       base_val = '0;
            1:       base_val = 48'hFFFF_FFFF_FFFF;
            2:       base_val = rand48();
            default: base_val = {16'hFFFF, 32'($urandom())};
        endcase
        drain();
        // Upper bits of the size and count words carry junk the block must ignore
        program_pool({junk[63:48], size_val}, {junk[36:0], count_val}, base_val);
        for (int unsigned k = 0; k < items; k++)
        begin
            if (!calm && $urandom_range(0, 79) == 0)
                drain();
            send_word(next_request());
        end
    endtask

    initial
    begin
        ledger = new();
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_CHUNK_SIZE;
        cfg_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pool: grants, double free, misaligned, last chunk, above range
        send_word(get_word());
        send_word(get_word());
        send_word(free_word(48'd64));
        send_word(free_word(48'd64));
        send_word(free_word(48'd8));
        send_word(free_word(48'd65472));
        send_word(free_word(48'd65536));
        send_word(free_word(48'hFFFF_FFFF_FFFF));
        send_word(free_word(48'd0));
        drain();

        // Size below alignment, count of zero, base at the top: one chunk only
        program_pool(48'd3, 48'd0, 48'hFFFF_FFFF_FFFF);
        send_word(get_word());
        send_word(get_word());
        send_word(free_word(48'hFFFF_FFFF_FFFE));
        send_word(free_word(48'd0));
        send_word(free_word(48'hFFFF_FFFF_FFFF));
        send_word(free_word(48'hFFFF_FFFF_FFFF));
        drain();

        // Largest size, count above the maximum: second grant wraps the address space
        program_pool(48'hFFFF_FFFF, 48'd2047, 48'hFFFF_FFFF_FF00);
        send_word(get_word());
        send_word(get_word());
        send_word(free_word(48'h0000_FFFF_FEF8));
        send_word(free_word(48'hFFFF_FFFF_FF00));
        drain();

        // Shrink the size with chunk 1 still out; its free follows the new grid
        write_register(CFG_CHUNK_SIZE, 48'd8);
        cfg_write <= 1'b0;
        send_word(free_word(48'hFFFF_FFFF_FF08));
        send_word(free_word(48'hFFFF_FFFF_FF08));

        // Random traffic over a spread of pool settings; calm phases run without idling
        for (int unsigned p = 0; p < 9; p++)
        begin
            calm = (p == 4) || (p == 8);
            random_phase(p, 160);
        end

        drain();
        repeat (24) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
            $display("fixed_chunk_pool_allocator_top_tb: clean");
        else
            $display("fixed_chunk_pool_allocator_top_tb: errors");
        $finish;
    end
endmodule
